/* hdl/timestamp_ordered_stream_merge_defines.svh */
// Assertion macros used by the checker of the merge block.
`ifndef TIMESTAMP_ORDERED_STREAM_MERGE_DEFINES_SVH
`define TIMESTAMP_ORDERED_STREAM_MERGE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define TOSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define TOSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tosm_pkg.sv */
`default_nettype none
package tosm_pkg;

   localparam int SOURCES        = 16;
   localparam int STAMP_BITS     = 48;
   localparam int IDX_BITS       = $clog2(SOURCES);

   localparam int REQ_BITS       = 2;
   localparam int SOURCE_BITS    = 4;
   localparam int IN_STAMP_BITS  = 48;
   localparam int TAG_BITS       = 32;
   localparam int BYTES_BITS     = 16;
   localparam int STATUS_BITS    = 2;
   localparam int OUT_STAMP_BITS = 48;
   localparam int COUNT_BITS     = 32;
   localparam int TOTAL_BITS     = 40;

   localparam logic [REQ_BITS-1:0] REQ_DELIVER = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_EXHAUST = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_READ    = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_EVENT   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_WAITING = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_DELIVER,
      OP_EXHAUST,
      OP_TAKE
   } cell_op_type;

   // Command broadcast to every cell; only the addressed cell acts on it.
   typedef struct packed {
      cell_op_type             op;
      logic [IDX_BITS-1:0]     target;
      logic [STAMP_BITS-1:0]   stamp;
      logic [TAG_BITS-1:0]     tag;
      logic [BYTES_BITS-1:0]   bytes;
   } cell_cmd_type;

   // Running minimum handed from cell to cell.
   typedef struct packed {
      logic                    any;
      logic                    waiting;
      logic                    found;
      logic [IDX_BITS-1:0]     idx;
      logic [STAMP_BITS-1:0]   stamp;
      logic [TAG_BITS-1:0]     tag;
      logic [COUNT_BITS-1:0]   count;
      logic [TOTAL_BITS-1:0]   total;
   } scan_type;

endpackage
`default_nettype wire

/* hdl/tosm_if.sv */
`default_nettype none
interface tosm_req_if;
   logic                                valid;
   logic                                ready;
   logic [tosm_pkg::REQ_BITS-1:0]       req_type;
   logic [tosm_pkg::SOURCE_BITS-1:0]    source_id;
   logic [tosm_pkg::IN_STAMP_BITS-1:0]  stamp;
   logic [tosm_pkg::TAG_BITS-1:0]       tag;
   logic [tosm_pkg::BYTES_BITS-1:0]     byte_count;

   modport source (output valid, req_type, source_id, stamp, tag, byte_count, input ready);
   modport sink   (input valid, req_type, source_id, stamp, tag, byte_count, output ready);
endinterface

interface tosm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tosm_pkg::STATUS_BITS-1:0]    status;
   logic [tosm_pkg::SOURCE_BITS-1:0]    winner;
   logic [tosm_pkg::OUT_STAMP_BITS-1:0] out_stamp;
   logic [tosm_pkg::TAG_BITS-1:0]       out_tag;
   logic [tosm_pkg::COUNT_BITS-1:0]     events_taken;
   logic [tosm_pkg::TOTAL_BITS-1:0]     bytes_total;

   modport source (output valid, status, winner, out_stamp, out_tag, events_taken,
                   bytes_total, input ready);
   modport sink   (input valid, status, winner, out_stamp, out_tag, events_taken,
                   bytes_total, output ready);
endinterface
`default_nettype wire

/* hdl/tosm_cell.sv */
`default_nettype none
module tosm_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tosm_pkg::IDX_BITS-1:0]  idx,
   input  wire tosm_pkg::cell_cmd_type         cmd,
   input  wire tosm_pkg::scan_type             scan_prev,
   output tosm_pkg::scan_type                  scan_next
);

   logic                                active_ff;
   logic                                valid_ff;
   logic [tosm_pkg::STAMP_BITS-1:0]     stamp_ff;
   logic [tosm_pkg::TAG_BITS-1:0]       tag_ff;
   logic [tosm_pkg::COUNT_BITS-1:0]     count_ff;
   logic [tosm_pkg::TOTAL_BITS-1:0]     total_ff;
   tosm_pkg::scan_type                  scan_ff;
   tosm_pkg::scan_type                  scan_in;
   logic                                sel;
   logic [tosm_pkg::TOTAL_BITS:0]       sum;

   assign sel = (cmd.target == idx);
   assign sum = {1'b0, total_ff} + (tosm_pkg::TOTAL_BITS + 1)'(cmd.bytes);

   // Fold this source into the running minimum; a strict compare keeps lower index on ties.
   always_comb begin
      scan_in = scan_prev;
      if (active_ff) begin
         scan_in.any = 1'b1;
         if (!valid_ff) begin
            scan_in.waiting = 1'b1;
         end else if (!scan_prev.found || (stamp_ff < scan_prev.stamp)) begin
            scan_in.found = 1'b1;
            scan_in.idx   = idx;
            scan_in.stamp = stamp_ff;
            scan_in.tag   = tag_ff;
            scan_in.count = count_ff;
            scan_in.total = total_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   assign scan_next = scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         count_ff  <= '0;
         total_ff  <= '0;
      end else if (sel) begin
         case (cmd.op)
            tosm_pkg::OP_DELIVER: begin
               active_ff <= 1'b1;
               valid_ff  <= 1'b1;
               // saturate the byte total
               total_ff  <= sum[tosm_pkg::TOTAL_BITS] ? '1 : sum[tosm_pkg::TOTAL_BITS-1:0];
            end
            tosm_pkg::OP_EXHAUST: begin
               active_ff <= 1'b0;
               valid_ff  <= 1'b0;
               count_ff  <= '0;
               total_ff  <= '0;
            end
            tosm_pkg::OP_TAKE: begin
               valid_ff <= 1'b0;
               count_ff <= count_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel && (cmd.op == tosm_pkg::OP_DELIVER)) begin
         stamp_ff <= cmd.stamp;
         tag_ff   <= cmd.tag;
      end
   end

endmodule
`default_nettype wire

/* hdl/tosm_ctrl.sv */
`default_nettype none
module tosm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tosm_req_if.sink                  req_ch,
   tosm_rsp_if.source                rsp_ch,
   input  wire tosm_pkg::scan_type   scan_final,
   output tosm_pkg::cell_cmd_type    cmd
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type                             state_ff;
   logic [tosm_pkg::IDX_BITS-1:0]         count_ff;
   logic                                  rsp_valid_ff;
   logic [tosm_pkg::STATUS_BITS-1:0]      status_ff;
   logic [tosm_pkg::SOURCE_BITS-1:0]      winner_ff;
   logic [tosm_pkg::OUT_STAMP_BITS-1:0]   stamp_ff;
   logic [tosm_pkg::TAG_BITS-1:0]         tag_ff;
   logic [tosm_pkg::COUNT_BITS-1:0]       events_ff;
   logic [tosm_pkg::TOTAL_BITS-1:0]       total_ff;

   logic                                  accept;
   logic                                  in_range;
   logic                                  scan_done;
   logic                                  out_free;
   logic                                  finish;
   logic [tosm_pkg::STATUS_BITS-1:0]      status_in;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_range     = (32'(req_ch.source_id) < tosm_pkg::SOURCES);
   // the scan wave has passed the last cell once the count reaches the end of the row
   assign scan_done    = (count_ff == tosm_pkg::IDX_BITS'(tosm_pkg::SOURCES - 1));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign finish       = (state_ff == S_SCAN) && scan_done && out_free;

   always_comb begin
      if (scan_final.waiting) begin
         status_in = tosm_pkg::ST_WAITING;
      end else if (!scan_final.any) begin
         status_in = tosm_pkg::ST_EMPTY;
      end else begin
         status_in = tosm_pkg::ST_EVENT;
      end
   end

   always_comb begin
      cmd.op     = tosm_pkg::OP_NONE;
      cmd.target = tosm_pkg::IDX_BITS'(req_ch.source_id);
      cmd.stamp  = tosm_pkg::STAMP_BITS'(req_ch.stamp);
      cmd.tag    = req_ch.tag;
      cmd.bytes  = req_ch.byte_count;
      if (accept && in_range && (req_ch.req_type == tosm_pkg::REQ_DELIVER)) begin
         cmd.op = tosm_pkg::OP_DELIVER;
      end else if (accept && in_range && (req_ch.req_type == tosm_pkg::REQ_EXHAUST)) begin
         cmd.op = tosm_pkg::OP_EXHAUST;
      end else if (finish && (status_in == tosm_pkg::ST_EVENT)) begin
         cmd.op     = tosm_pkg::OP_TAKE;
         cmd.target = scan_final.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.ready && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               count_ff <= '0;
               if (accept && (req_ch.req_type == tosm_pkg::REQ_READ)) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (!scan_done) begin
                  count_ff <= count_ff + 1'b1;
               end else if (out_free) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= status_in;
                  if (status_in == tosm_pkg::ST_EVENT) begin
                     winner_ff <= tosm_pkg::SOURCE_BITS'(scan_final.idx);
                     stamp_ff  <= tosm_pkg::OUT_STAMP_BITS'(scan_final.stamp);
                     tag_ff    <= scan_final.tag;
                     events_ff <= scan_final.count + 1'b1;
                     total_ff  <= scan_final.total;
                  end else begin
                     winner_ff <= '0;
                     stamp_ff  <= '0;
                     tag_ff    <= '0;
                     events_ff <= '0;
                     total_ff  <= '0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.winner       = winner_ff;
   assign rsp_ch.out_stamp    = stamp_ff;
   assign rsp_ch.out_tag      = tag_ff;
   assign rsp_ch.events_taken = events_ff;
   assign rsp_ch.bytes_total  = total_ff;

endmodule
`default_nettype wire

/* hdl/timestamp_ordered_stream_merge.sv */
`default_nettype none
// Merges up to SOURCES event sources into one stream in timestamp order. Each source sits
// in a cell of its own holding one head event, an event count and a saturating byte
// total. Deliver and exhausted items take effect in the cycle they are accepted and give
// no result, so they can follow back to back. A read item waits for the running minimum
// to pass down the row of cells, one cell per cycle: its result is loaded into the output
// register when the scan ends, and the next item can be accepted in the cycle after. The
// next item may be accepted while that result waits; a later read whose scan ends while
// the output register is still full is held until the result is taken. The lowest source
// wins on equal timestamps, a read reports waiting if an active source has no head, and
// empty if no source is active.
module timestamp_ordered_stream_merge (
   input  wire logic   clock,
   input  wire logic   reset,
   tosm_req_if.sink    req_ch,
   tosm_rsp_if.source  rsp_ch
);

   tosm_pkg::cell_cmd_type  cmd;
   tosm_pkg::scan_type      scan_link [tosm_pkg::SOURCES+1];

   assign scan_link[0] = '0;

   for (genvar i = 0; i < tosm_pkg::SOURCES; i++) begin : g_cell
      tosm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .idx       (tosm_pkg::IDX_BITS'(i)),
         .cmd       (cmd),
         .scan_prev (scan_link[i]),
         .scan_next (scan_link[i+1])
      );
   end

   tosm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .scan_final (scan_link[tosm_pkg::SOURCES]),
      .cmd        (cmd)
   );

endmodule
`default_nettype wire

/* hdl/tosm_checker.sv */
`default_nettype none
`include "timestamp_ordered_stream_merge_defines.svh"
module tosm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic [tosm_pkg::REQ_BITS-1:0]       req_type,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [tosm_pkg::STATUS_BITS-1:0]    rsp_status,
   input wire logic [tosm_pkg::SOURCE_BITS-1:0]    rsp_winner,
   input wire logic [tosm_pkg::TAG_BITS-1:0]       rsp_tag,
   input wire logic [tosm_pkg::COUNT_BITS-1:0]     rsp_events
);

   `TOSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "item dropped while stalled")
   `TOSM_ASSERT_NEXT(a_read_blocks, clock, reset, req_valid && req_ready && (req_type == tosm_pkg::REQ_READ), !req_ready, "input taken during a read scan")
   `TOSM_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, (rsp_status == tosm_pkg::ST_EVENT) || (rsp_status == tosm_pkg::ST_EMPTY) || (rsp_status == tosm_pkg::ST_WAITING), "unknown status")
   `TOSM_ASSERT_NOW(a_no_event_zero, clock, reset, rsp_valid && (rsp_status != tosm_pkg::ST_EVENT), (rsp_winner == '0) && (rsp_tag == '0) && (rsp_events == '0), "payload not cleared")
   `TOSM_ASSERT_NOW(a_event_counted, clock, reset, rsp_valid && (rsp_status == tosm_pkg::ST_EVENT) && (rsp_events == '0), 1'b0, "event count not advanced")

endmodule

bind timestamp_ordered_stream_merge tosm_checker u_tosm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_type   (req_ch.req_type),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_winner (rsp_ch.winner),
   .rsp_tag    (rsp_ch.out_tag),
   .rsp_events (rsp_ch.events_taken)
);
`default_nettype wire
